// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the group-sum accumulator.
// Each file that asserts includes this header; it needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked in reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sgsa_pkg.sv =====
// Package of the sparse group-sum accumulator: sizes, codes, types and helpers.
// Used by the channel interfaces, the sum table RAM and the top level.
package sgsa_pkg;

  // Table geometry: one entry per (line, group) pair.
  localparam int LINES      = 256;
  localparam int GROUPS_MAX = 16;
  localparam int DEPTH      = LINES * GROUPS_MAX;
  localparam int LINE_W     = $clog2(LINES);
  localparam int GIDX_W     = $clog2(GROUPS_MAX);
  localparam int ADDR_W     = $clog2(DEPTH);

  // Field widths.
  localparam int FUNC_W  = 2;
  localparam int GROUP_W = 5;
  localparam int COUNT_W = 16;
  localparam int SUM_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Request function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_ACCUM = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS  = 1'b1;
  localparam logic [GROUP_W-1:0]   NUM_GROUPS_RST  = GROUP_W'(GROUPS_MAX);

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_A,
    S_RD_B
  } state_t;

  // Access request from the controller to the sum table.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SUM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // A group is valid when it lies in 1..num_groups and within the table.
  function automatic logic group_ok(input logic [GROUP_W-1:0] g,
                                    input logic [GROUP_W-1:0] n);
    return (g != '0) && (g <= n) && (g <= GROUP_W'(GROUPS_MAX));
  endfunction

  // Entry address of a line and a 1-based group.
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [LINE_W-1:0]  line,
                                                   input logic [GROUP_W-1:0] g);
    logic [GROUP_W-1:0] gi;
    gi = g - GROUP_W'(1);
    return {line, gi[GIDX_W-1:0]};
  endfunction

endpackage

// ===== sv/sgsa_chan_if.sv =====
// Valid/ready channel interfaces of the group-sum accumulator.
// Depends on sgsa_pkg for the field widths.
interface sgsa_in_if import sgsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [LINE_W-1:0]         line;
  logic [GROUP_W-1:0]        new_group;
  logic [GROUP_W-1:0]        old_group;
  logic [COUNT_W-1:0]        count_value;
  logic signed [SUM_W-1:0]   write_data;

  modport source (output valid, func, line, new_group, old_group, count_value,
                  write_data, input ready);
  modport sink (input valid, func, line, new_group, old_group, count_value,
                write_data, output ready);
endinterface

interface sgsa_out_if import sgsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] read_sum;
  logic                    group_error;

  modport source (output valid, read_sum, group_error, input ready);
  modport sink (input valid, read_sum, group_error, output ready);
endinterface

// ===== sv/sgsa_sum_ram.sv =====
// Single-port-write, single-port-read sum table with a registered read.
// Depends on sgsa_pkg for the geometry and the request struct.
module sgsa_sum_ram import sgsa_pkg::*; (
  input  logic             clk,
  input  ram_req_t         req,
  output logic [SUM_W-1:0] rd_data
);

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/sparse_group_sum_accumulator_top.sv =====
// Top level of the sparse group-sum accumulator: controller, configuration
// registers and result register. Depends on sgsa_pkg, the channel interfaces
// and sgsa_sum_ram.
//
//   port       direction  contents
//   in_chan    sink       func, line, new_group, old_group, count_value, write_data
//   out_chan   source     read_sum, group_error (one result per request)
//   cfg_*      input      write enable, register index, write data
//
// A write, an error or an ignored request is finished in S_IDLE; a read or a
// plain accumulate goes on through S_RD_A; a change-mode move goes through
// S_RD_A and S_RD_B, since both entries go through the single read port and
// write port of the sum table. After reset a clearing pass zeroes the table's 4096
// entries, one entry a cycle; no request is taken then. A new request is
// taken while a result waits only if that result is taken in the same cycle.
`include "assert_macros.svh"

module sparse_group_sum_accumulator_top import sgsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sgsa_in_if.sink               in_chan,
  sgsa_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               change_mode_r;
  logic [GROUP_W-1:0] num_groups_r;

  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  addr_a_r, addr_a_nxt;
  logic [ADDR_W-1:0]  addr_b_r, addr_b_nxt;
  logic               move_r, move_nxt;
  logic               is_read_r, is_read_nxt;

  logic                    out_valid_r;
  logic signed [SUM_W-1:0] read_sum_r;
  logic                    group_error_r;

  logic             in_ready;
  logic             accept;
  logic             ng_ok, og_ok;
  logic             out_load;
  logic [SUM_W-1:0] res_sum;
  logic             res_err;
  ram_req_t         ram_req;
  logic [SUM_W-1:0] ram_rdata;

  // Sum table.
  sgsa_sum_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  // Handshake and group checks of the request at the input.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept   = in_chan.valid && in_ready;
  assign ng_ok    = group_ok(in_chan.new_group, num_groups_r);
  assign og_ok    = group_ok(in_chan.old_group, num_groups_r);
  assign in_chan.ready = in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_mode_r <= 1'b0;
      num_groups_r  <= NUM_GROUPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANGE_MODE: change_mode_r <= cfg_wdata[0];
        CFG_NUM_GROUPS:  num_groups_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Controller state and clear counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Request context held while the table is being updated.
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    addr_a_r  <= addr_a_nxt;
    addr_b_r  <= addr_b_nxt;
    move_r    <= move_nxt;
    is_read_r <= is_read_nxt;
  end

  // Next state, table accesses and result loading.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cnt_nxt     = cnt_r;
    addr_a_nxt  = addr_a_r;
    addr_b_nxt  = addr_b_r;
    move_nxt    = move_r;
    is_read_nxt = is_read_r;
    ram_req     = '0;
    out_load    = 1'b0;
    res_sum     = '0;
    res_err     = 1'b0;

    case (state_r)
      // Zero the table one entry a cycle.
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        clr_cnt_nxt   = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a request; finish it at once or start the table read.
      S_IDLE: begin
        if (accept) begin
          cnt_nxt     = in_chan.count_value;
          addr_a_nxt  = entry_addr(in_chan.line, in_chan.new_group);
          addr_b_nxt  = entry_addr(in_chan.line, in_chan.old_group);
          move_nxt    = 1'b0;
          is_read_nxt = 1'b0;
          case (func_t'(in_chan.func))
            FUNC_WRITE: begin
              out_load = 1'b1;
              res_err  = !ng_ok;
              if (ng_ok) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = addr_a_nxt;
                ram_req.wdata = $unsigned(in_chan.write_data);
              end
            end
            FUNC_ACCUM: begin
              if (change_mode_r) begin
                if (!ng_ok || !og_ok) begin
                  out_load = 1'b1;
                  res_err  = 1'b1;
                end else if (in_chan.new_group == in_chan.old_group) begin
                  out_load = 1'b1;
                end else begin
                  ram_req.re    = 1'b1;
                  ram_req.raddr = addr_a_nxt;
                  move_nxt      = 1'b1;
                  state_nxt     = S_RD_A;
                end
              end else if (!ng_ok) begin
                out_load = 1'b1;
                res_err  = 1'b1;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = addr_a_nxt;
                state_nxt     = S_RD_A;
              end
            end
            FUNC_READ: begin
              if (!ng_ok) begin
                out_load = 1'b1;
                res_err  = 1'b1;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = addr_a_nxt;
                is_read_nxt   = 1'b1;
                state_nxt     = S_RD_A;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // First entry is back: return it, or add the count and maybe read the
      // old group's entry.
      S_RD_A: begin
        if (is_read_r) begin
          out_load  = 1'b1;
          res_sum   = ram_rdata;
          state_nxt = S_IDLE;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = addr_a_r;
          ram_req.wdata = ram_rdata + SUM_W'(cnt_r);
          if (move_r) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = addr_b_r;
            state_nxt     = S_RD_B;
          end else begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      // Old group's entry is back: subtract the count.
      S_RD_B: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_b_r;
        ram_req.wdata = ram_rdata - SUM_W'(cnt_r);
        out_load      = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: valid control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      read_sum_r    <= $signed(res_sum);
      group_error_r <= res_err;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_sum    = read_sum_r;
  assign out_chan.group_error = group_error_r;

  // No request is taken before the table is cleared.
  `ASSERT_ALWAYS(a_no_accept_in_clear, (state_r == S_CLEAR) |-> !in_ready, "request taken during clear")

  // A result is only loaded into a free or departing result register.
  `ASSERT_CLK(a_no_result_overrun, out_load |-> (!out_valid_r || out_chan.ready), "result overwritten")

  // A move never writes and reads the same entry in one cycle.
  `ASSERT_CLK(a_no_same_entry, (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr), "write and read hit the same entry")

  // An error result carries a zero sum.
  `ASSERT_CLK(a_error_zero_sum, (out_valid_r && group_error_r) |-> (read_sum_r == '0), "error result with nonzero sum")

  // The second table access follows only the first one of a move.
  `ASSERT_CLK(a_rd_b_after_rd_a, (state_r == S_RD_B) |-> ($past(state_r) == S_RD_A && move_r), "bad path to second entry")

endmodule
